/* hdl/scct_pkg.sv */
// Shared types and constants for the swept circle collision time pipeline.
`timescale 1ns / 1ps
`default_nettype none
package scct_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;

   localparam int FS_W   = COORD_WIDTH - 1;   // radii and frame step
   localparam int DIFF_W = COORD_WIDTH + 1;   // present centre difference
   localparam int VEL_W  = COORD_WIDTH + 2;   // change of difference over the frame
   localparam int PP_W   = 2 * VEL_W;         // first-level products
   localparam int A_W    = 2 * VEL_W - 1;     // a = v.v
   localparam int MAG_W  = 2 * VEL_W;         // wide multiplier operand
   localparam int HALF_W = MAG_W / 2;
   localparam int PROD_W = 2 * MAG_W;
   localparam int ROOT_W = A_W;               // floor sqrt of the discriminant
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 2;
   localparam int T_W    = MAG_W + 2;         // chosen root numerator
   localparam int Q_W    = COORD_WIDTH - 1;   // quotient bits below saturation
   localparam int DIVR_W = A_W + Q_W;

   localparam int LATENCY = 4 + 2 + 1 + ROOT_W + 2 + 2 + 1 + Q_W + 1;

   localparam logic [FS_W-1:0] FRAME_STEP_RESET = FS_W'(1) << FRAC_BITS;
   localparam logic [COORD_WIDTH-1:0] TIME_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic [COORD_WIDTH-1:0] TIME_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] first_x_now;
      logic signed [COORD_WIDTH-1:0] first_y_now;
      logic signed [COORD_WIDTH-1:0] first_x_next;
      logic signed [COORD_WIDTH-1:0] first_y_next;
      logic signed [COORD_WIDTH-1:0] second_x_now;
      logic signed [COORD_WIDTH-1:0] second_y_now;
      logic signed [COORD_WIDTH-1:0] second_x_next;
      logic signed [COORD_WIDTH-1:0] second_y_next;
      logic [FS_W-1:0]               first_radius;
      logic [FS_W-1:0]               second_radius;
      logic                          second_movable;
   } req_type;

   typedef struct packed {
      logic                          hit;
      logic signed [COORD_WIDTH-1:0] contact_time;
   } rsp_type;

   typedef struct packed {
      logic [A_W-1:0]          a;
      logic signed [MAG_W-1:0] h;
   } geo_type;

   typedef struct packed {
      logic    ok;
      geo_type geo;
   } root_side_type;

   typedef struct packed {
      logic           ok;
      logic           neg;
      logic           sat;
      logic [A_W-1:0] a;
   } div_side_type;

endpackage
`default_nettype wire

/* hdl/swept_circle_collision_time.sv */
// The delay from the start edge to the result strobe is LATENCY in the package.
// Throughput: one word per cycle; busy never rises, the pipeline never stalls.
// Most of the pipeline is the square root (one bit per stage) and the divider (one bit per stage).
// Reset (synchronous) empties the pipeline and sets the frame step to 1.0.
// Results leave on a one-cycle strobe; the receiver cannot hold them off.
`timescale 1ns / 1ps
`default_nettype none
module swept_circle_collision_time (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire scct_pkg::req_type    req_data,
   output logic                      rsp_strobe,
   output scct_pkg::rsp_type         rsp_data,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [scct_pkg::FS_W-1:0] csr_data
);

   logic [scct_pkg::FS_W-1:0] frame_step_ff;

   // front
   logic                        fr_valid;
   scct_pkg::geo_type           fr_geo;
   logic [scct_pkg::MAG_W-1:0]  fr_habs, fr_cabs;
   logic                        fr_c_neg;

   // coefficient products
   logic [scct_pkg::PROD_W-1:0] hh_p, ac_p;
   logic                        m1_valid_ff [2];
   scct_pkg::geo_type           m1_geo_ff   [2];
   logic                        m1_cneg_ff  [2];

   // discriminant
   logic                        d_valid_ff;
   logic [scct_pkg::PROD_W:0]   d_wide;
   logic [scct_pkg::RAD_W-1:0]  rad_ff, rad_in;
   scct_pkg::root_side_type     dside_ff, dside_in;

   // square root
   logic                        sq_valid;
   logic [scct_pkg::ROOT_W-1:0] sq_root;
   scct_pkg::root_side_type     sq_side;

   // root choice
   logic                          t1_valid_ff;
   logic signed [scct_pkg::T_W-1:0] t1_ff, t1_in, neg_h, s_ext, m_small;
   logic                          t1_ok_ff;
   logic [scct_pkg::A_W-1:0]      t1_a_ff;

   logic                          t2_valid_ff;
   logic [scct_pkg::MAG_W-1:0]    tmag_ff, tmag_in;
   logic                          t2_ok_ff, t2_neg_ff, t2_neg_in;
   logic [scct_pkg::A_W-1:0]      t2_a_ff;

   // scaling product
   logic [scct_pkg::PROD_W-1:0]   p_p;
   logic                          m2_valid_ff [2];
   logic                          m2_ok_ff    [2];
   logic                          m2_neg_ff   [2];
   logic [scct_pkg::A_W-1:0]      m2_a_ff     [2];

   // saturation check
   logic                          st_valid_ff;
   logic [scct_pkg::DIVR_W-1:0]   st_rem_ff, st_rem_in;
   scct_pkg::div_side_type        st_side_ff, st_side_in;

   // divider
   logic                          dv_valid;
   logic [scct_pkg::Q_W-1:0]      dv_quot;
   logic                          dv_rem_nz;
   scct_pkg::div_side_type        dv_side;

   // result
   logic                          rsp_strobe_ff;
   scct_pkg::rsp_type             rsp_data_ff, rsp_data_in;
   logic [scct_pkg::COORD_WIDTH-1:0] qq;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_step_ff <= scct_pkg::FRAME_STEP_RESET;
      end else if (csr_valid && csr_ready) begin
         frame_step_ff <= csr_data;
      end
   end

   scct_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_data   (req_data),
      .out_valid (fr_valid),
      .out_geo   (fr_geo),
      .out_habs  (fr_habs),
      .out_cabs  (fr_cabs),
      .out_c_neg (fr_c_neg)
   );

   scct_mul u_mul_hh (
      .clock (clock),
      .x     (fr_habs),
      .y     (fr_habs),
      .p     (hh_p)
   );

   scct_mul u_mul_ac (
      .clock (clock),
      .x     (scct_pkg::MAG_W'(fr_geo.a)),
      .y     (fr_cabs),
      .p     (ac_p)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff[0] <= 1'b0;
         m1_valid_ff[1] <= 1'b0;
      end else begin
         m1_valid_ff[0] <= fr_valid;
         m1_valid_ff[1] <= m1_valid_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      m1_geo_ff[0]  <= fr_geo;
      m1_geo_ff[1]  <= m1_geo_ff[0];
      m1_cneg_ff[0] <= fr_c_neg;
      m1_cneg_ff[1] <= m1_cneg_ff[0];
   end

   // D = h*h - a*c; a zero forces h zero and D zero, so D > 0 covers both checks
   always_comb begin
      if (m1_cneg_ff[1]) begin
         d_wide = {1'b0, hh_p} + {1'b0, ac_p};
      end else begin
         d_wide = {1'b0, hh_p} - {1'b0, ac_p};
      end
      rad_in       = d_wide[scct_pkg::RAD_W-1:0];
      dside_in.ok  = !d_wide[scct_pkg::PROD_W] && (d_wide != '0);
      dside_in.geo = m1_geo_ff[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= m1_valid_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      rad_ff   <= rad_in;
      dside_ff <= dside_in;
   end

   scct_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid_ff),
      .in_rad    (rad_ff),
      .in_side   (dside_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // smaller root when -h - s is nonnegative, else the larger one
   always_comb begin
      neg_h   = -(scct_pkg::T_W'(sq_side.geo.h));
      s_ext   = $signed(scct_pkg::T_W'(sq_root));
      m_small = neg_h - s_ext;
      t1_in   = m_small[scct_pkg::T_W-1] ? neg_h + s_ext : m_small;
   end

   always_comb begin
      tmag_in   = t1_ff[scct_pkg::T_W-1] ? scct_pkg::MAG_W'(-t1_ff) : scct_pkg::MAG_W'(t1_ff);
      t2_neg_in = t1_ff[scct_pkg::T_W-1] && (frame_step_ff != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_valid_ff <= 1'b0;
         t2_valid_ff <= 1'b0;
      end else begin
         t1_valid_ff <= sq_valid;
         t2_valid_ff <= t1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      t1_ff     <= t1_in;
      t1_ok_ff  <= sq_side.ok;
      t1_a_ff   <= sq_side.geo.a;
      tmag_ff   <= tmag_in;
      t2_neg_ff <= t2_neg_in;
      t2_ok_ff  <= t1_ok_ff;
      t2_a_ff   <= t1_a_ff;
   end

   scct_mul u_mul_fs (
      .clock (clock),
      .x     (tmag_ff),
      .y     (scct_pkg::MAG_W'(frame_step_ff)),
      .p     (p_p)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff[0] <= 1'b0;
         m2_valid_ff[1] <= 1'b0;
      end else begin
         m2_valid_ff[0] <= t2_valid_ff;
         m2_valid_ff[1] <= m2_valid_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      m2_ok_ff[0]  <= t2_ok_ff;
      m2_ok_ff[1]  <= m2_ok_ff[0];
      m2_neg_ff[0] <= t2_neg_ff;
      m2_neg_ff[1] <= m2_neg_ff[0];
      m2_a_ff[0]   <= t2_a_ff;
      m2_a_ff[1]   <= m2_a_ff[0];
   end

   // quotient at or above the signed limit saturates either way
   always_comb begin
      st_side_in.ok  = m2_ok_ff[1];
      st_side_in.neg = m2_neg_ff[1];
      st_side_in.a   = m2_a_ff[1];
      st_side_in.sat = p_p >= (scct_pkg::PROD_W'(m2_a_ff[1]) << scct_pkg::Q_W);
      st_rem_in      = p_p[scct_pkg::DIVR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff <= 1'b0;
      end else begin
         st_valid_ff <= m2_valid_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      st_rem_ff  <= st_rem_in;
      st_side_ff <= st_side_in;
   end

   scct_div u_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (st_valid_ff),
      .in_rem     (st_rem_ff),
      .in_side    (st_side_ff),
      .out_valid  (dv_valid),
      .out_quot   (dv_quot),
      .out_rem_nz (dv_rem_nz),
      .out_side   (dv_side)
   );

   // negative results round toward minus infinity
   always_comb begin
      qq = {1'b0, dv_quot} + scct_pkg::COORD_WIDTH'(dv_rem_nz);
      rsp_data_in.hit = dv_side.ok;
      if (!dv_side.ok) begin
         rsp_data_in.contact_time = '0;
      end else if (dv_side.sat) begin
         rsp_data_in.contact_time = dv_side.neg ? scct_pkg::TIME_MIN : scct_pkg::TIME_MAX;
      end else if (dv_side.neg) begin
         rsp_data_in.contact_time = -qq;
      end else begin
         rsp_data_in.contact_time = {1'b0, dv_quot};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##(scct_pkg::LATENCY) rsp_strobe)
      else $error("accepted word gave no result strobe at the pipeline latency");

   a_latency_back: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, scct_pkg::LATENCY))
      else $error("result strobe without a word accepted at the pipeline latency");

   a_frame_step_hold: assert property (@(posedge clock) disable iff (reset)
      !(csr_valid && csr_ready) |=> $stable(frame_step_ff))
      else $error("frame step changed without a register write");

endmodule
`default_nettype wire

/* hdl/scct_front.sv */
// Front stages: differences, first products, quadratic coefficients and magnitudes.
`timescale 1ns / 1ps
`default_nettype none
module scct_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            in_valid,
   input  wire scct_pkg::req_type               in_data,
   output logic                                 out_valid,
   output scct_pkg::geo_type                    out_geo,
   output logic [scct_pkg::MAG_W-1:0]           out_habs,
   output logic [scct_pkg::MAG_W-1:0]           out_cabs,
   output logic                                 out_c_neg
);

   // stage 1
   logic s1_valid_ff;
   logic signed [scct_pkg::DIFF_W-1:0] dx_ff, dy_ff, dx_in, dy_in, dxn, dyn;
   logic signed [scct_pkg::VEL_W-1:0]  vx_ff, vy_ff, vx_in, vy_in;
   logic [scct_pkg::COORD_WIDTH-1:0]   rsum_ff, rsum_in;
   logic signed [scct_pkg::COORD_WIDTH-1:0] x2, y2;

   // stage 2
   logic s2_valid_ff;
   logic signed [scct_pkg::PP_W-1:0] vxx_ff, vyy_ff, dvx_ff, dvy_ff, dxx_ff, dyy_ff;
   logic signed [scct_pkg::PP_W-1:0] vxx_in, vyy_in, dvx_in, dvy_in, dxx_in, dyy_in;
   logic [2*scct_pkg::COORD_WIDTH-1:0] rss_ff, rss_in;

   // stage 3
   logic s3_valid_ff;
   logic [scct_pkg::A_W-1:0]          a_ff, a_in;
   logic signed [scct_pkg::MAG_W-1:0] h_ff, h_in, c_ff, c_in;

   // stage 4
   logic s4_valid_ff;
   scct_pkg::geo_type geo_ff, geo_in;
   logic [scct_pkg::MAG_W-1:0] habs_ff, habs_in, cabs_ff, cabs_in;
   logic c_neg_ff, c_neg_in;

   always_comb begin
      x2    = in_data.second_movable ? in_data.second_x_next : in_data.second_x_now;
      y2    = in_data.second_movable ? in_data.second_y_next : in_data.second_y_now;
      dx_in = scct_pkg::DIFF_W'(in_data.first_x_now) - scct_pkg::DIFF_W'(in_data.second_x_now);
      dy_in = scct_pkg::DIFF_W'(in_data.first_y_now) - scct_pkg::DIFF_W'(in_data.second_y_now);
      dxn   = scct_pkg::DIFF_W'(in_data.first_x_next) - scct_pkg::DIFF_W'(x2);
      dyn   = scct_pkg::DIFF_W'(in_data.first_y_next) - scct_pkg::DIFF_W'(y2);
      vx_in = scct_pkg::VEL_W'(dxn) - scct_pkg::VEL_W'(dx_in);
      vy_in = scct_pkg::VEL_W'(dyn) - scct_pkg::VEL_W'(dy_in);
      rsum_in = scct_pkg::COORD_WIDTH'(in_data.first_radius)
              + scct_pkg::COORD_WIDTH'(in_data.second_radius);
   end

   always_comb begin
      vxx_in = vx_ff * vx_ff;
      vyy_in = vy_ff * vy_ff;
      dvx_in = dx_ff * vx_ff;
      dvy_in = dy_ff * vy_ff;
      dxx_in = dx_ff * dx_ff;
      dyy_in = dy_ff * dy_ff;
      rss_in = rsum_ff * rsum_ff;
   end

   always_comb begin
      a_in = scct_pkg::A_W'(vxx_ff + vyy_ff);
      h_in = dvx_ff + dvy_ff;
      c_in = dxx_ff + dyy_ff - $signed(scct_pkg::PP_W'(rss_ff));
   end

   always_comb begin
      geo_in.a  = a_ff;
      geo_in.h  = h_ff;
      habs_in   = h_ff[scct_pkg::MAG_W-1] ? scct_pkg::MAG_W'(-h_ff) : scct_pkg::MAG_W'(h_ff);
      cabs_in   = c_ff[scct_pkg::MAG_W-1] ? scct_pkg::MAG_W'(-c_ff) : scct_pkg::MAG_W'(c_ff);
      c_neg_in  = c_ff[scct_pkg::MAG_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      vx_ff   <= vx_in;
      vy_ff   <= vy_in;
      rsum_ff <= rsum_in;
      vxx_ff  <= vxx_in;
      vyy_ff  <= vyy_in;
      dvx_ff  <= dvx_in;
      dvy_ff  <= dvy_in;
      dxx_ff  <= dxx_in;
      dyy_ff  <= dyy_in;
      rss_ff  <= rss_in;
      a_ff    <= a_in;
      h_ff    <= h_in;
      c_ff    <= c_in;
      geo_ff  <= geo_in;
      habs_ff <= habs_in;
      cabs_ff <= cabs_in;
      c_neg_ff <= c_neg_in;
   end

   assign out_valid = s4_valid_ff;
   assign out_geo   = geo_ff;
   assign out_habs  = habs_ff;
   assign out_cabs  = cabs_ff;
   assign out_c_neg = c_neg_ff;

endmodule
`default_nettype wire

/* hdl/scct_mul.sv */
// Two-stage wide unsigned multiplier built from four half-width partial products.
`timescale 1ns / 1ps
`default_nettype none
module scct_mul (
   input  wire logic                          clock,
   input  wire logic [scct_pkg::MAG_W-1:0]    x,
   input  wire logic [scct_pkg::MAG_W-1:0]    y,
   output logic [scct_pkg::PROD_W-1:0]        p
);

   localparam int HW = scct_pkg::HALF_W;

   logic [2*HW-1:0] ll_ff, lh_ff, hl_ff, hh_ff, ll_in, lh_in, hl_in, hh_in;
   logic [scct_pkg::PROD_W-1:0] p_ff, p_in;

   always_comb begin
      ll_in = x[HW-1:0] * y[HW-1:0];
      lh_in = x[HW-1:0] * y[2*HW-1:HW];
      hl_in = x[2*HW-1:HW] * y[HW-1:0];
      hh_in = x[2*HW-1:HW] * y[2*HW-1:HW];
      p_in  = {hh_ff, ll_ff}
            + (scct_pkg::PROD_W'(lh_ff) << HW)
            + (scct_pkg::PROD_W'(hl_ff) << HW);
   end

   always_ff @(posedge clock) begin
      ll_ff <= ll_in;
      lh_ff <= lh_in;
      hl_ff <= hl_in;
      hh_ff <= hh_in;
      p_ff  <= p_in;
   end

   assign p = p_ff;

endmodule
`default_nettype wire

/* hdl/scct_sqrt.sv */
// Pipelined floor square root, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module scct_sqrt (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire logic [scct_pkg::RAD_W-1:0]    in_rad,
   input  wire scct_pkg::root_side_type       in_side,
   output logic                               out_valid,
   output logic [scct_pkg::ROOT_W-1:0]        out_root,
   output scct_pkg::root_side_type            out_side
);

   localparam int N = scct_pkg::ROOT_W;

   logic                          vld_ff  [N];
   logic [scct_pkg::REM_W-1:0]    rem_ff  [N];
   logic [N-1:0]                  root_ff [N];
   logic [scct_pkg::RAD_W-1:0]    rad_ff  [N];
   scct_pkg::root_side_type       side_ff [N];

   for (genvar j = 0; j < N; j++) begin : g_stage
      logic                        vld_prev;
      logic [scct_pkg::REM_W-1:0]  rem_prev, rem_in;
      logic [N-1:0]                root_prev, root_in;
      logic [scct_pkg::RAD_W-1:0]  rad_prev;
      scct_pkg::root_side_type     side_prev;
      logic [scct_pkg::REM_W+1:0]  trial, test;

      if (j == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = in_rad;
         assign side_prev = in_side;
      end else begin : g_next
         assign vld_prev  = vld_ff[j-1];
         assign rem_prev  = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
         assign rad_prev  = rad_ff[j-1];
         assign side_prev = side_ff[j-1];
      end

      // bring down the next two radicand bits, try 4*root + 1
      always_comb begin
         trial = {rem_prev, rad_prev[scct_pkg::RAD_W-1-2*j -: 2]};
         test  = (scct_pkg::REM_W+2)'({root_prev, 2'b01});
         if (trial >= test) begin
            rem_in  = scct_pkg::REM_W'(trial - test);
            root_in = {root_prev[N-2:0], 1'b1};
         end else begin
            rem_in  = scct_pkg::REM_W'(trial);
            root_in = {root_prev[N-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else begin
            vld_ff[j] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[j]  <= rem_in;
         root_ff[j] <= root_in;
         rad_ff[j]  <= rad_prev;
         side_ff[j] <= side_prev;
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_root  = root_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule
`default_nettype wire

/* hdl/scct_div.sv */
// Pipelined restoring divider, one quotient bit per stage, quotient below the saturation limit.
`timescale 1ns / 1ps
`default_nettype none
module scct_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire logic [scct_pkg::DIVR_W-1:0]   in_rem,
   input  wire scct_pkg::div_side_type        in_side,
   output logic                               out_valid,
   output logic [scct_pkg::Q_W-1:0]           out_quot,
   output logic                               out_rem_nz,
   output scct_pkg::div_side_type             out_side
);

   localparam int N = scct_pkg::Q_W;

   logic                          vld_ff  [N];
   logic [scct_pkg::DIVR_W-1:0]   rem_ff  [N];
   logic [N-1:0]                  quot_ff [N];
   scct_pkg::div_side_type        side_ff [N];

   for (genvar j = 0; j < N; j++) begin : g_stage
      logic                          vld_prev;
      logic [scct_pkg::DIVR_W-1:0]   rem_prev, rem_in, divisor;
      logic [N-1:0]                  quot_prev, quot_in;
      scct_pkg::div_side_type        side_prev;
      logic                          ge;

      if (j == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign rem_prev  = in_rem;
         assign quot_prev = '0;
         assign side_prev = in_side;
      end else begin : g_next
         assign vld_prev  = vld_ff[j-1];
         assign rem_prev  = rem_ff[j-1];
         assign quot_prev = quot_ff[j-1];
         assign side_prev = side_ff[j-1];
      end

      always_comb begin
         divisor = scct_pkg::DIVR_W'(side_prev.a) << (N-1-j);
         ge      = rem_prev >= divisor;
         rem_in  = ge ? rem_prev - divisor : rem_prev;
         quot_in = quot_prev;
         quot_in[N-1-j] = ge;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else begin
            vld_ff[j] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[j]  <= rem_in;
         quot_ff[j] <= quot_in;
         side_ff[j] <= side_prev;
      end
   end

   assign out_valid  = vld_ff[N-1];
   assign out_quot   = quot_ff[N-1];
   assign out_rem_nz = rem_ff[N-1] != '0;
   assign out_side   = side_ff[N-1];

endmodule
`default_nettype wire
